FILE: sv/cbz_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cubic Bezier sampler package
// Shared widths, angle constants and the arctangent table used by the
// curve evaluation and angle pipelines.
// ----------------------------------------------------------------------------
package cbz_pkg;

   // Default number of curve segments.
   localparam int CBZ_STEPS_DEF = 100;

   // Field widths.
   localparam int CBZ_COORD_W = 14;
   localparam int CBZ_IDX_W   = 7;
   localparam int CBZ_PT_W    = 18;
   localparam int CBZ_ANG_W   = 15;

   // Curve parameter t in signed Q2.16.
   localparam int CBZ_T_W = 18;

   // Difference of two Q16 curve values.
   localparam int CBZ_DIFF_W = 39;

   // Largest point output value.
   localparam int CBZ_PT_MAX = 262143;

   // Angles in units of 2^-16 degree.
   localparam int CBZ_DEG90  = 5898240;
   localparam int CBZ_DEG180 = 11796480;

   // Rotation steps and atan(2^-k) in units of 2^-16 degree.
   localparam int CBZ_CORDIC_STEPS = 22;
   localparam logic [21:0] CBZ_ATAN_TAB [CBZ_CORDIC_STEPS] = '{
      22'd2949120, 22'd1740967, 22'd919879, 22'd466945, 22'd234379, 22'd117304,
      22'd58666,   22'd29335,   22'd14668,  22'd7334,   22'd3667,   22'd1833,
      22'd917,     22'd458,     22'd229,    22'd115,    22'd57,     22'd29,
      22'd14,      22'd7,       22'd4,      22'd2
   };

endpackage

FILE: sv/cbz_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sample request channel
// Valid/ready channel carrying four control points and a sample index.
// ----------------------------------------------------------------------------
interface cbz_req_if
   import cbz_pkg::*;
();
   logic                   valid;
   logic                   ready;
   logic [CBZ_COORD_W-1:0] p0_x;
   logic [CBZ_COORD_W-1:0] p0_y;
   logic [CBZ_COORD_W-1:0] p1_x;
   logic [CBZ_COORD_W-1:0] p1_y;
   logic [CBZ_COORD_W-1:0] p2_x;
   logic [CBZ_COORD_W-1:0] p2_y;
   logic [CBZ_COORD_W-1:0] p3_x;
   logic [CBZ_COORD_W-1:0] p3_y;
   logic [CBZ_IDX_W-1:0]   sample_index;

   modport source (
      output valid, p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y, sample_index,
      input  ready
   );
   modport sink (
      input  valid, p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y, sample_index,
      output ready
   );
endinterface

FILE: sv/cbz_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sample response channel
// Valid/ready channel carrying the curve point and the tangent angle.
// ----------------------------------------------------------------------------
interface cbz_rsp_if
   import cbz_pkg::*;
();
   logic                        valid;
   logic                        ready;
   logic [CBZ_PT_W-1:0]         point_x;
   logic [CBZ_PT_W-1:0]         point_y;
   logic signed [CBZ_ANG_W-1:0] tangent_angle;

   modport source (
      output valid, point_x, point_y, tangent_angle,
      input  ready
   );
   modport sink (
      input  valid, point_x, point_y, tangent_angle,
      output ready
   );
endinterface

FILE: sv/cbz_poly.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cubic polynomial evaluator
// Seven-stage Horner pipeline for one axis. Evaluates the curve at three
// parameters and returns the rounded center point and the neighbor difference.
// ----------------------------------------------------------------------------
module cbz_poly
   import cbz_pkg::*;
(
   input  logic                         clock,
   input  logic                         adv,
   input  logic [CBZ_COORD_W-1:0]       p0,
   input  logic [CBZ_COORD_W-1:0]       p1,
   input  logic [CBZ_COORD_W-1:0]       p2,
   input  logic [CBZ_COORD_W-1:0]       p3,
   input  logic signed [CBZ_T_W-1:0]    t_in [3],
   output logic signed [CBZ_DIFF_W-1:0] diff,
   output logic [CBZ_PT_W-1:0]          point
);

   // Stage A: polynomial coefficients.
   logic signed [19:0]          e0, e1, e2, e3;
   logic signed [16:0]          c1_a_in, c1_a_ff;
   logic signed [17:0]          c2_a_in, c2_a_ff;
   logic signed [17:0]          c3_a_in, c3_a_ff;
   logic [CBZ_COORD_W-1:0]      p0_a_ff;
   logic signed [CBZ_T_W-1:0]   t_a_ff [3];

   assign e0 = $signed({6'b0, p0});
   assign e1 = $signed({6'b0, p1});
   assign e2 = $signed({6'b0, p2});
   assign e3 = $signed({6'b0, p3});

   always_comb begin
      c1_a_in = 17'(3 * (e1 - e0));
      c2_a_in = 18'(3 * (e2 - 2 * e1 + e0));
      c3_a_in = 18'(e3 - 3 * e2 + 3 * e1 - e0);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         c1_a_ff <= c1_a_in;
         c2_a_ff <= c2_a_in;
         c3_a_ff <= c3_a_in;
         p0_a_ff <= p0;
         t_a_ff  <= t_in;
      end
   end

   // Stage B: a2 = c3*t + c2*2^16.
   logic signed [35:0]        m2 [3];
   logic signed [35:0]        a2_b_in [3];
   logic signed [35:0]        a2_b_ff [3];
   logic signed [CBZ_T_W-1:0] t_b_ff [3];
   logic signed [16:0]        c1_b_ff;
   logic [CBZ_COORD_W-1:0]    p0_b_ff;

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         m2[j]      = c3_a_ff * t_a_ff[j];
         a2_b_in[j] = m2[j] + 36'($signed({c2_a_ff, 16'b0}));
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a2_b_ff <= a2_b_in;
         t_b_ff  <= t_a_ff;
         c1_b_ff <= c1_a_ff;
         p0_b_ff <= p0_a_ff;
      end
   end

   // Stage C: partial products of a2*t, split at bit 17.
   logic signed [36:0]        ph_c_in [3];
   logic signed [35:0]        pl_c_in [3];
   logic signed [36:0]        ph_c_ff [3];
   logic signed [35:0]        pl_c_ff [3];
   logic signed [CBZ_T_W-1:0] t_c_ff [3];
   logic signed [16:0]        c1_c_ff;
   logic [CBZ_COORD_W-1:0]    p0_c_ff;

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         ph_c_in[j] = $signed(a2_b_ff[j][35:17]) * t_b_ff[j];
         pl_c_in[j] = $signed({1'b0, a2_b_ff[j][16:0]}) * t_b_ff[j];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ph_c_ff <= ph_c_in;
         pl_c_ff <= pl_c_in;
         t_c_ff  <= t_b_ff;
         c1_c_ff <= c1_b_ff;
         p0_c_ff <= p0_b_ff;
      end
   end

   // Stage D: a1 = round(a2*t / 2^16) + c1*2^16.
   logic signed [54:0]        s_d [3];
   logic signed [36:0]        a1_d_in [3];
   logic signed [36:0]        a1_d_ff [3];
   logic signed [CBZ_T_W-1:0] t_d_ff [3];
   logic [CBZ_COORD_W-1:0]    p0_d_ff;

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         s_d[j]     = $signed({ph_c_ff[j], 17'b0}) + pl_c_ff[j] + 55'sd32768;
         a1_d_in[j] = 37'(s_d[j] >>> 16) + 37'($signed({c1_c_ff, 16'b0}));
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a1_d_ff <= a1_d_in;
         t_d_ff  <= t_c_ff;
         p0_d_ff <= p0_c_ff;
      end
   end

   // Stage E: partial products of a1*t, split at bit 17.
   logic signed [37:0]     ph_e_in [3];
   logic signed [35:0]     pl_e_in [3];
   logic signed [37:0]     ph_e_ff [3];
   logic signed [35:0]     pl_e_ff [3];
   logic [CBZ_COORD_W-1:0] p0_e_ff;

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         ph_e_in[j] = $signed(a1_d_ff[j][36:17]) * t_d_ff[j];
         pl_e_in[j] = $signed({1'b0, a1_d_ff[j][16:0]}) * t_d_ff[j];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ph_e_ff <= ph_e_in;
         pl_e_ff <= pl_e_in;
         p0_e_ff <= p0_d_ff;
      end
   end

   // Stage F: a0 = round(a1*t / 2^16) + p0*2^16.
   logic signed [55:0] s_f [3];
   logic signed [37:0] a0_f_in [3];
   logic signed [37:0] a0_f_ff [3];

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         s_f[j]     = $signed({ph_e_ff[j], 17'b0}) + pl_e_ff[j] + 56'sd32768;
         a0_f_in[j] = 38'(s_f[j] >>> 16) + $signed({8'b0, p0_e_ff, 16'b0});
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a0_f_ff <= a0_f_in;
      end
   end

   // Stage G: neighbor difference and the rounded, clamped Q14.4 point.
   logic signed [CBZ_DIFF_W-1:0] diff_in, diff_ff;
   logic signed [25:0]           q_g;
   logic [CBZ_PT_W-1:0]          point_in, point_ff;

   always_comb begin
      diff_in = CBZ_DIFF_W'(a0_f_ff[2]) - CBZ_DIFF_W'(a0_f_ff[0]);
      q_g     = 26'((a0_f_ff[1] + 38'sd2048) >>> 12);
      if (q_g < 0) begin
         point_in = '0;
      end else if (q_g > 26'(CBZ_PT_MAX)) begin
         point_in = CBZ_PT_W'(CBZ_PT_MAX);
      end else begin
         point_in = q_g[CBZ_PT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         diff_ff  <= diff_in;
         point_ff <= point_in;
      end
   end

   assign diff  = diff_ff;
   assign point = point_ff;

endmodule

FILE: sv/cbz_atan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tangent angle unit
// Pipelined atan2: magnitude and normalize over three stages, one CORDIC
// rotation per stage, then quadrant mapping and rounding to 1/64 degree.
// ----------------------------------------------------------------------------
module cbz_atan
   import cbz_pkg::*;
(
   input  logic                         clock,
   input  logic                         adv,
   input  logic signed [CBZ_DIFF_W-1:0] dx,
   input  logic signed [CBZ_DIFF_W-1:0] dy,
   output logic signed [CBZ_ANG_W-1:0]  angle
);

   localparam int NW = 41;
   localparam int CW = 44;
   localparam int ZW = 25;
   localparam int NS = CBZ_CORDIC_STEPS;

   typedef struct packed {
      logic neg_x;
      logic neg_y;
      logic zero;
   } quad_type;

   // Stage 1: magnitudes, their maximum and the quadrant flags.
   logic [NW-1:0] x1_in, y1_in, m1_in, x1_ff, y1_ff, m1_ff;
   quad_type      q1_in, q1_ff;

   always_comb begin
      x1_in       = NW'(dx < 0 ? -dx : dx);
      y1_in       = NW'(dy < 0 ? -dy : dy);
      m1_in       = (x1_in > y1_in) ? x1_in : y1_in;
      q1_in.neg_x = dx < 0;
      q1_in.neg_y = dy < 0;
      q1_in.zero  = (dx == 0) && (dy == 0);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         x1_ff <= x1_in;
         y1_ff <= y1_in;
         m1_ff <= m1_in;
         q1_ff <= q1_in;
      end
   end

   // Stage 2: coarse normalize, shifting by 32, 16 and 8 while the top bit stays clear.
   logic [NW-1:0] x2_in, y2_in, m2_in, x2_ff, y2_ff, m2_ff;
   quad_type      q2_ff;

   always_comb begin
      x2_in = x1_ff;
      y2_in = y1_ff;
      m2_in = m1_ff;
      if (m2_in[NW-1:NW-32] == '0) begin
         x2_in = x2_in << 32;
         y2_in = y2_in << 32;
         m2_in = m2_in << 32;
      end
      if (m2_in[NW-1:NW-16] == '0) begin
         x2_in = x2_in << 16;
         y2_in = y2_in << 16;
         m2_in = m2_in << 16;
      end
      if (m2_in[NW-1:NW-8] == '0) begin
         x2_in = x2_in << 8;
         y2_in = y2_in << 8;
         m2_in = m2_in << 8;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         x2_ff <= x2_in;
         y2_ff <= y2_in;
         m2_ff <= m2_in;
         q2_ff <= q1_ff;
      end
   end

   // Stage 3: fine normalize by 4, 2 and 1; the result seeds the rotations.
   logic [NW-1:0]        x3_in, y3_in, m3_in;
   logic signed [CW-1:0] cx_ff [NS+1];
   logic signed [CW-1:0] cy_ff [NS+1];
   logic signed [ZW-1:0] cz_ff [NS+1];
   quad_type             cq_ff [NS+1];

   always_comb begin
      x3_in = x2_ff;
      y3_in = y2_ff;
      m3_in = m2_ff;
      if (m3_in[NW-1:NW-4] == '0) begin
         x3_in = x3_in << 4;
         y3_in = y3_in << 4;
         m3_in = m3_in << 4;
      end
      if (m3_in[NW-1:NW-2] == '0) begin
         x3_in = x3_in << 2;
         y3_in = y3_in << 2;
         m3_in = m3_in << 2;
      end
      if (!m3_in[NW-1]) begin
         x3_in = x3_in << 1;
         y3_in = y3_in << 1;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         cx_ff[0] <= $signed(CW'(x3_in));
         cy_ff[0] <= $signed(CW'(y3_in));
         cz_ff[0] <= '0;
         cq_ff[0] <= q2_ff;
      end
   end

   // Vectoring rotations, one per stage, driving y toward zero.
   for (genvar k = 0; k < NS; k++) begin : g_rot
      logic signed [CW-1:0] xs, ys;
      logic signed [ZW-1:0] step;

      assign xs   = cx_ff[k] >>> k;
      assign ys   = cy_ff[k] >>> k;
      assign step = ZW'(CBZ_ATAN_TAB[k]);

      always_ff @(posedge clock) begin
         if (adv) begin
            if (cy_ff[k] >= 0) begin
               cx_ff[k+1] <= cx_ff[k] + ys;
               cy_ff[k+1] <= cy_ff[k] - xs;
               cz_ff[k+1] <= cz_ff[k] + step;
            end else begin
               cx_ff[k+1] <= cx_ff[k] - ys;
               cy_ff[k+1] <= cy_ff[k] + xs;
               cz_ff[k+1] <= cz_ff[k] - step;
            end
            cq_ff[k+1] <= cq_ff[k];
         end
      end
   end

   // Final stage: clamp to the first quadrant, map by signs, round to 1/64 degree.
   logic [23:0]                 zc;
   logic [13:0]                 mag;
   logic signed [CBZ_ANG_W-1:0] angle_in, angle_ff;

   always_comb begin
      if (cz_ff[NS] < 0) begin
         zc = '0;
      end else if (cz_ff[NS] > ZW'(CBZ_DEG90)) begin
         zc = 24'(CBZ_DEG90);
      end else begin
         zc = cz_ff[NS][23:0];
      end
      if (cq_ff[NS].neg_x) begin
         zc = 24'(CBZ_DEG180) - zc;
      end
      mag = 14'((zc + 24'd512) >> 10);
      if (cq_ff[NS].zero) begin
         angle_in = '0;
      end else if (cq_ff[NS].neg_y) begin
         angle_in = -$signed({1'b0, mag});
      end else begin
         angle_in = $signed({1'b0, mag});
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         angle_ff <= angle_in;
      end
   end

   assign angle = angle_ff;

endmodule

FILE: sv/cubic_bezier_sample_tangent.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cubic Bezier sample with tangent angle
// Evaluates a cubic Bezier curve at t = i/STEPS in Q14.4 and reports the
// tangent direction from the neighboring samples in 1/64-degree units.
// ----------------------------------------------------------------------------
// The block takes one request beat per clock and returns one response beat per
// request, in order, after acceptance, through seven stages of Horner
// evaluation for both axes (two split multiplies per step), three stages of
// magnitude and normalize, 22 CORDIC rotation stages and one rounding stage.
// The whole pipeline holds when a finished response is not taken, so
// req_ch.ready follows rsp_ch.ready in the same cycle whenever the output
// register is full. Sample indexes above STEPS are treated as STEPS.
module cubic_bezier_sample_tangent
   import cbz_pkg::*;
#(
   parameter int STEPS = CBZ_STEPS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   cbz_req_if.sink   req_ch,
   cbz_rsp_if.source rsp_ch
);

   localparam int POLY_LAT = 7;
   localparam int ATAN_LAT = 26;
   localparam int LAT      = POLY_LAT + ATAN_LAT;
   localparam int TAB_N    = 2 ** CBZ_IDX_W + 1;
   localparam int TI_W     = CBZ_IDX_W + 1;

   // Global advance: every stage moves unless the output beat is stuck.
   logic           adv;
   logic [LAT-1:0] vld_ff;

   assign adv          = !vld_ff[LAT-1] || rsp_ch.ready;
   assign req_ch.ready = adv;
   assign rsp_ch.valid = vld_ff[LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[LAT-2:0], req_ch.valid};
      end
   end

   // Parameter table: t(k) = round(k * 2^16 / STEPS), built at elaboration.
   logic signed [CBZ_T_W-1:0] t_tab [TAB_N];

   for (genvar k = 0; k < TAB_N; k++) begin : g_ttab
      localparam longint TQ = (longint'(k) * 131072 + STEPS) / (2 * STEPS);
      assign t_tab[k] = CBZ_T_W'(TQ);
   end

   // Saturate the index and look up the three parameters.
   logic [CBZ_IDX_W-1:0]      i_sat;
   logic [TI_W-1:0]           idx_c, idx_p, idx_m;
   logic signed [CBZ_T_W-1:0] t_sel [3];

   always_comb begin
      i_sat = (int'(req_ch.sample_index) > STEPS) ? CBZ_IDX_W'(STEPS)
                                                  : req_ch.sample_index;
      idx_c = {1'b0, i_sat};
      idx_p = idx_c + TI_W'(1);
      idx_m = (i_sat == '0) ? TI_W'(1) : idx_c - TI_W'(1);
      t_sel[0] = (i_sat == '0) ? -t_tab[idx_m] : t_tab[idx_m];
      t_sel[1] = t_tab[idx_c];
      t_sel[2] = t_tab[idx_p];
   end

   // Curve evaluation for each axis.
   logic signed [CBZ_DIFF_W-1:0] dx, dy;
   logic [CBZ_PT_W-1:0]          px, py;

   cbz_poly u_poly_x (
      .clock (clock),
      .adv   (adv),
      .p0    (req_ch.p0_x),
      .p1    (req_ch.p1_x),
      .p2    (req_ch.p2_x),
      .p3    (req_ch.p3_x),
      .t_in  (t_sel),
      .diff  (dx),
      .point (px)
   );

   cbz_poly u_poly_y (
      .clock (clock),
      .adv   (adv),
      .p0    (req_ch.p0_y),
      .p1    (req_ch.p1_y),
      .p2    (req_ch.p2_y),
      .p3    (req_ch.p3_y),
      .t_in  (t_sel),
      .diff  (dy),
      .point (py)
   );

   // Tangent angle.
   logic signed [CBZ_ANG_W-1:0] angle;

   cbz_atan u_atan (
      .clock (clock),
      .adv   (adv),
      .dx    (dx),
      .dy    (dy),
      .angle (angle)
   );

   // Delay line that keeps the point aligned with its angle.
   logic [2*CBZ_PT_W-1:0] pd_ff [ATAN_LAT];

   always_ff @(posedge clock) begin
      if (adv) begin
         pd_ff[0] <= {px, py};
         for (int k = 1; k < ATAN_LAT; k++) begin
            pd_ff[k] <= pd_ff[k-1];
         end
      end
   end

   assign rsp_ch.point_x       = pd_ff[ATAN_LAT-1][2*CBZ_PT_W-1:CBZ_PT_W];
   assign rsp_ch.point_y       = pd_ff[ATAN_LAT-1][CBZ_PT_W-1:0];
   assign rsp_ch.tangent_angle = angle;

`ifndef SYNTHESIS
   // A stuck response beat must hold off new requests.
   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.ready |-> !req_ch.ready)
      else $error("request taken while the response beat is stalled");

   // With the output register empty the pipeline never refuses a beat.
   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_ch.valid |-> req_ch.ready)
      else $error("pipeline refused a beat while the output was empty");

   // Reset empties the pipeline.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_ch.valid)
      else $error("response valid right after reset");

   // The angle never leaves the half-turn range.
   a_angle_range: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (rsp_ch.tangent_angle >= -15'sd11520) &&
                       (rsp_ch.tangent_angle <= 15'sd11520))
      else $error("tangent angle out of range");
`endif

endmodule

FILE: verif/cbz_tangent_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bezier sample checker
// Watches the request and response channels, computes the expected curve
// point and tangent angle for every accepted request and compares them in
// order with the responses.
// ----------------------------------------------------------------------------
module cbz_tangent_checker
   import cbz_pkg::*;
#(
   parameter int STEPS = CBZ_STEPS_DEF
) (
   input  logic   clock,
   input  logic   reset,
   cbz_req_if     req_ch,
   cbz_rsp_if     rsp_ch,
   output int     fail_count,
   output int     pending_count
);

   typedef struct packed {
      logic [CBZ_PT_W-1:0]         point_x;
      logic [CBZ_PT_W-1:0]         point_y;
      logic signed [CBZ_ANG_W-1:0] tangent_angle;
   } sample_type;

   sample_type expected_samples[$];

   // Parameter k as signed Q2.16, rounded to nearest.
   function automatic longint param_q16(longint k);
      longint mag;
      longint q;
      mag = (k < 0) ? -k : k;
      q   = (mag * 131072 + longint'(STEPS)) / (2 * longint'(STEPS));
      return (k < 0) ? -q : q;
   endfunction

   // Horner evaluation of one axis in Q16; >>> on longint is a floor shift.
   function automatic longint horner_q16(longint p0, longint p1, longint p2,
                                         longint p3, longint t);
      longint c1;
      longint c2;
      longint c3;
      longint a2;
      longint a1;
      c1 = 3 * (p1 - p0);
      c2 = 3 * (p2 - 2 * p1 + p0);
      c3 = p3 - 3 * p2 + 3 * p1 - p0;
      a2 = c3 * t + c2 * 65536;
      a1 = ((a2 * t + 32768) >>> 16) + c1 * 65536;
      return ((a1 * t + 32768) >>> 16) + p0 * 65536;
   endfunction

   function automatic logic [CBZ_PT_W-1:0] to_point(longint a0);
      longint q;
      q = (a0 + 2048) >>> 12;
      if (q < 0) q = 0;
      if (q > longint'(CBZ_PT_MAX)) q = longint'(CBZ_PT_MAX);
      return q[CBZ_PT_W-1:0];
   endfunction

   // Vectoring rotation in the first quadrant, then quadrant fix and rounding.
   function automatic logic signed [CBZ_ANG_W-1:0] tangent_64ths(longint dx,
                                                                 longint dy);
      longint x;
      longint y;
      longint z;
      longint xs;
      longint ys;
      x = (dx < 0) ? -dx : dx;
      y = (dy < 0) ? -dy : dy;
      z = 0;
      if (x == 0 && y == 0) return '0;
      while (((x > y) ? x : y) < (64'sd1 <<< 40)) begin
         x = x * 2;
         y = y * 2;
      end
      for (int k = 0; k < CBZ_CORDIC_STEPS; k++) begin
         xs = x >>> k;
         ys = y >>> k;
         if (y >= 0) begin
            x = x + ys;
            y = y - xs;
            z = z + longint'(CBZ_ATAN_TAB[k]);
         end else begin
            x = x - ys;
            y = y + xs;
            z = z - longint'(CBZ_ATAN_TAB[k]);
         end
      end
      if (z < 0) z = 0;
      if (z > longint'(CBZ_DEG90)) z = longint'(CBZ_DEG90);
      if (dx < 0) z = longint'(CBZ_DEG180) - z;
      z = (z + 512) >>> 10;
      if (dy < 0) z = -z;
      return z[CBZ_ANG_W-1:0];
   endfunction

   function automatic sample_type predict_sample(longint px[4], longint py[4],
                                                 longint idx);
      sample_type s;
      longint     tm;
      longint     tc;
      longint     tp;
      longint     dx;
      longint     dy;
      if (idx > longint'(STEPS)) idx = longint'(STEPS);
      tm = param_q16(idx - 1);
      tc = param_q16(idx);
      tp = param_q16(idx + 1);
      dx = horner_q16(px[0], px[1], px[2], px[3], tp)
         - horner_q16(px[0], px[1], px[2], px[3], tm);
      dy = horner_q16(py[0], py[1], py[2], py[3], tp)
         - horner_q16(py[0], py[1], py[2], py[3], tm);
      s.point_x       = to_point(horner_q16(px[0], px[1], px[2], px[3], tc));
      s.point_y       = to_point(horner_q16(py[0], py[1], py[2], py[3], tc));
      s.tangent_angle = tangent_64ths(dx, dy);
      return s;
   endfunction

   // Record a prediction per request beat and compare each response beat.
   always @(posedge clock) begin
      longint     px[4];
      longint     py[4];
      sample_type got;
      sample_type want;
      if (reset) begin
         fail_count    <= 0;
         pending_count <= 0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            px = '{longint'(req_ch.p0_x), longint'(req_ch.p1_x),
                   longint'(req_ch.p2_x), longint'(req_ch.p3_x)};
            py = '{longint'(req_ch.p0_y), longint'(req_ch.p1_y),
                   longint'(req_ch.p2_y), longint'(req_ch.p3_y)};
            expected_samples = {expected_samples,
                                predict_sample(px, py, longint'(req_ch.sample_index))};
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = '{rsp_ch.point_x, rsp_ch.point_y, rsp_ch.tangent_angle};
            if (expected_samples.size() == 0) begin
               if (fail_count < 10)
                  $display("unexpected response beat: x=%0d y=%0d ang=%0d",
                           got.point_x, got.point_y, got.tangent_angle);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_samples.pop_front();
               if (got !== want) begin
                  if (fail_count < 10)
                     $display("mismatch: expected x=%0d y=%0d ang=%0d, got x=%0d y=%0d ang=%0d",
                              want.point_x, want.point_y, want.tangent_angle,
                              got.point_x, got.point_y, got.tangent_angle);
                  fail_count <= fail_count + 1;
               end
            end
         end
         pending_count <= expected_samples.size();
      end
   end

endmodule

FILE: verif/cubic_bezier_sample_tangent_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bezier sampler testbench
// Drives directed and random control points and sample indexes with random
// gaps and response stalls, including one long stall that backs up the
// pipeline, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module cubic_bezier_sample_tangent_tb
   import cbz_pkg::*;
;

   localparam int NUM_RANDOM = 1800;
   localparam int DRAIN_CYCLES = 80;
   localparam int CYCLE_LIMIT = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count;
   int   pending_count;
   int   cycle_count = 0;
   bit   hold_off = 1'b0;
   bit   stim_done = 1'b0;

   cbz_req_if req_ch ();
   cbz_rsp_if rsp_ch ();

   cubic_bezier_sample_tangent dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   cbz_tangent_checker checker_i (
      .clock         (clock),
      .reset         (reset),
      .req_ch        (req_ch),
      .rsp_ch        (rsp_ch),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   always #4 clock = ~clock;

   initial begin
      req_ch.valid = 1'b0;
      {req_ch.p0_x, req_ch.p0_y, req_ch.p1_x, req_ch.p1_y} = '0;
      {req_ch.p2_x, req_ch.p2_y, req_ch.p3_x, req_ch.p3_y} = '0;
      req_ch.sample_index = '0;
      rsp_ch.ready = 1'b0;
   end

   // Send one request beat after a gap and hold it until it is taken.
   // Valid stays high between beats when there is no gap.
   task automatic send_sample(int pts[8], int idx, int gap);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.p0_x         <= CBZ_COORD_W'(pts[0]);
      req_ch.p0_y         <= CBZ_COORD_W'(pts[1]);
      req_ch.p1_x         <= CBZ_COORD_W'(pts[2]);
      req_ch.p1_y         <= CBZ_COORD_W'(pts[3]);
      req_ch.p2_x         <= CBZ_COORD_W'(pts[4]);
      req_ch.p2_y         <= CBZ_COORD_W'(pts[5]);
      req_ch.p3_x         <= CBZ_COORD_W'(pts[6]);
      req_ch.p3_y         <= CBZ_COORD_W'(pts[7]);
      req_ch.sample_index <= CBZ_IDX_W'(idx);
      do @(posedge clock); while (!req_ch.ready);
   endtask

   function automatic int rand_coord();
      case ($urandom_range(0, 5))
         0:       return 0;
         1:       return 16383;
         2:       return int'($urandom_range(0, 15));
         3:       return int'($urandom_range(16368, 16383));
         default: return int'($urandom_range(0, 16383));
      endcase
   endfunction

   // Stimulus: directed corners, then random curves with runs of indexes.
   initial begin
      int pts[8];
      int idx;
      int gap;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      // Flat and degenerate curves: zero tangent, all at one point.
      pts = '{default: 0};
      send_sample(pts, 0, 0);
      send_sample(pts, 50, 0);
      pts = '{default: 16383};
      send_sample(pts, 100, 0);
      // Horizontal line backwards gives +180 degrees; forwards gives 0.
      pts = '{16383, 5, 10000, 5, 5000, 5, 0, 5};
      send_sample(pts, 0, 1);
      send_sample(pts, 50, 0);
      pts = '{0, 9, 5000, 9, 10000, 9, 16383, 9};
      send_sample(pts, 100, 0);
      // Vertical lines both ways.
      pts = '{7, 0, 7, 6000, 7, 12000, 7, 16383};
      send_sample(pts, 30, 0);
      pts = '{7, 16383, 7, 12000, 7, 6000, 7, 0};
      send_sample(pts, 70, 0);
      // Extreme overshoot so the extrapolated ends leave the range.
      pts = '{0, 16383, 16383, 0, 16383, 0, 0, 16383};
      send_sample(pts, 0, 0);
      send_sample(pts, 100, 0);
      send_sample(pts, 1, 0);
      send_sample(pts, 99, 0);
      pts = '{16383, 0, 0, 16383, 0, 16383, 16383, 0};
      send_sample(pts, 100, 2);
      send_sample(pts, 0, 0);
      // Indexes past the end are saturated.
      send_sample(pts, 101, 0);
      send_sample(pts, 127, 0);
      pts = '{100, 200, 16383, 16383, 0, 0, 300, 400};
      send_sample(pts, 127, 0);
      send_sample(pts, 64, 0);
      // Random curves, mostly in-range indexes, with a long stall midway.
      for (int n = 0; n < NUM_RANDOM; n++) begin
         if (n % 8 == 0)
            foreach (pts[j]) pts[j] = rand_coord();
         if (n == NUM_RANDOM / 2) hold_off = 1'b1;
         idx = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 127))
                                           : int'($urandom_range(0, 100));
         gap = ((n / 200) % 3 == 1) ? 0 : int'($urandom_range(0, 14));
         send_sample(pts, idx, gap);
      end
      req_ch.valid <= 1'b0;
      stim_done = 1'b1;
   end

   // Response side: random stalls, no stalls in some stretches, one long hold.
   initial begin
      int stall;
      bit held;
      held = 1'b0;
      @(negedge reset);
      forever begin
         if (hold_off && !held) begin
            held = 1'b1;
            rsp_ch.ready <= 1'b0;
            for (int c = 0; c < 300; c++) @(posedge clock);
         end
         stall = ((cycle_count / 3000) % 3 == 2) ? 0 : int'($urandom_range(0, 14));
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
      end
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   // Verdict after the queue drains, or fail on the cycle limit.
   initial begin
      wait (stim_done);
      while (pending_count != 0 && cycle_count < CYCLE_LIMIT) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("end of test: mismatches");
      end else if (fail_count == 0 && pending_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT + DRAIN_CYCLES + 10);
      $display("end of test: mismatches");
      $finish;
   end

endmodule
